### hw/rtl/tiered_counter_sketch_update_defines.svh
// Assertion macros for the tiered counter sketch update block.
// Included by the top level; no other dependencies.
`ifndef TIERED_COUNTER_SKETCH_UPDATE_DEFINES_SVH
`define TIERED_COUNTER_SKETCH_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
// checked at every rising edge, ignored while reset is held
`define TCSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every rising edge, reset included
`define TCSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TCSU_ASSERT(lbl, prop, msg)
`define TCSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/tcsu_pkg.sv
// Shared constants and types for the tiered counter sketch update block.
// No dependencies; used by tcsu_tree and tiered_counter_sketch_update.
`timescale 1ns / 1ps
`default_nettype none

package tcsu_pkg;

    // leaf store depth is a power of two: the leaf index wraps by truncation
    localparam int LEAF_AW      = 16;
    localparam int LEAF_ENTRIES = 1 << LEAF_AW;
    localparam int FANIN_SHIFT  = 3;
    localparam int MID_AW       = LEAF_AW - FANIN_SHIFT;
    localparam int MID_ENTRIES  = 1 << MID_AW;
    localparam int TOP_AW       = LEAF_AW - 2 * FANIN_SHIFT;
    localparam int TOP_ENTRIES  = 1 << TOP_AW;

    localparam int IDX_W  = 16;
    localparam int INC_W  = 16;
    localparam int LEAF_W = 17;
    localparam int MID_W  = 18;
    localparam int TOP_W  = 32;
    localparam int EST_W  = 32;

    localparam logic [LEAF_W-1:0] LEAF_LIMIT = LEAF_W'(254);
    localparam logic [MID_W-1:0]  MID_LIMIT  = MID_W'(65534);
    // offset added to the top counter once both lower levels are full
    localparam logic [EST_W-1:0]  TOP_BASE   = EST_W'(254 + 65534);

    typedef struct packed {
        logic               clear;
        logic [LEAF_AW-1:0] clear_addr;
        logic               rd;
        logic               leaf_stage;
        logic               mid_stage;
        logic               top_stage;
        logic               est_stage;
    } tree_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/tcsu_tree.sv
// One counter tree: leaf, middle and top counter memories with their update logic.
// Depends on tcsu_pkg; sequenced by the top level through a tree_ctl_t word.
`timescale 1ns / 1ps
`default_nettype none

module tcsu_tree
    import tcsu_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] leaf_index,
    input  logic [INC_W-1:0] increment,
    input  tree_ctl_t        ctl,
    output logic [EST_W-1:0] estimate
);

    logic [LEAF_W-1:0] leaf_mem [LEAF_ENTRIES];
    logic [MID_W-1:0]  mid_mem  [MID_ENTRIES];
    logic [TOP_W-1:0]  top_mem  [TOP_ENTRIES];

    logic [LEAF_W-1:0] leaf_rd_reg;
    logic [MID_W-1:0]  mid_rd_reg;
    logic [TOP_W-1:0]  top_rd_reg;

    logic [LEAF_W-1:0] leaf_val_reg, leaf_val_next;
    logic [MID_W-1:0]  mid_val_reg, mid_val_next;
    logic [TOP_W-1:0]  top_val_reg, top_val_next;
    logic [EST_W-1:0]  estimate_reg, estimate_next;

    logic [LEAF_AW-1:0] leaf_addr, leaf_wa;
    logic [MID_AW-1:0]  mid_addr, mid_wa;
    logic [TOP_AW-1:0]  top_addr, top_wa;

    logic              leaf_low, leaf_done, mid_take, mid_done, top_take;
    logic [LEAF_W-1:0] leaf_sum, leaf_wd;
    logic [MID_W-1:0]  mid_sum, mid_wd;
    logic [TOP_W:0]    top_sum;
    logic [TOP_W-1:0]  top_sat, top_wd;
    logic [EST_W:0]    est_sum;
    logic              leaf_we, mid_we, top_we;

    assign leaf_addr = LEAF_AW'(leaf_index);
    assign mid_addr  = MID_AW'(leaf_addr >> FANIN_SHIFT);
    assign top_addr  = TOP_AW'(leaf_addr >> (2 * FANIN_SHIFT));

    // leaf level
    assign leaf_low      = (leaf_rd_reg <= LEAF_LIMIT);
    assign leaf_sum      = leaf_rd_reg + LEAF_W'(increment);
    assign leaf_val_next = leaf_low ? leaf_sum : leaf_rd_reg;

    // middle level, only when the leaf has overflowed
    assign leaf_done    = (leaf_val_reg <= LEAF_LIMIT);
    assign mid_take     = !leaf_done && (mid_rd_reg <= MID_LIMIT);
    assign mid_sum      = mid_rd_reg + MID_W'(increment);
    assign mid_val_next = mid_take ? mid_sum : mid_rd_reg;

    // top level saturates
    assign mid_done     = (mid_val_reg <= MID_LIMIT);
    assign top_take     = !leaf_done && !mid_done;
    assign top_sum      = {1'b0, top_rd_reg} + (TOP_W + 1)'(increment);
    assign top_sat      = top_sum[TOP_W] ? '1 : top_sum[TOP_W-1:0];
    assign top_val_next = top_take ? top_sat : top_rd_reg;

    assign est_sum = {1'b0, TOP_BASE} + (EST_W + 1)'(top_val_reg);

    always_comb
    begin
        if (leaf_done)
        begin
            estimate_next = EST_W'(leaf_val_reg);
        end
        else if (mid_done)
        begin
            estimate_next = EST_W'(LEAF_LIMIT) + EST_W'(mid_val_reg);
        end
        else
        begin
            estimate_next = est_sum[EST_W] ? '1 : est_sum[EST_W-1:0];
        end
    end

    // write ports: the clearing sweep shares them with the updates
    assign leaf_we = ctl.clear || (ctl.leaf_stage && leaf_low);
    assign leaf_wa = ctl.clear ? ctl.clear_addr : leaf_addr;
    assign leaf_wd = ctl.clear ? '0 : leaf_sum;

    assign mid_we = ctl.clear || (ctl.mid_stage && mid_take);
    assign mid_wa = ctl.clear ? MID_AW'(ctl.clear_addr >> FANIN_SHIFT) : mid_addr;
    assign mid_wd = ctl.clear ? '0 : mid_sum;

    assign top_we = ctl.clear || (ctl.top_stage && top_take);
    assign top_wa = ctl.clear ? TOP_AW'(ctl.clear_addr >> (2 * FANIN_SHIFT)) : top_addr;
    assign top_wd = ctl.clear ? '0 : top_sat;

    always_ff @(posedge clk)
    begin
        if (leaf_we)
        begin
            leaf_mem[leaf_wa] <= leaf_wd;
        end
        if (ctl.rd)
        begin
            leaf_rd_reg <= leaf_mem[leaf_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_we)
        begin
            mid_mem[mid_wa] <= mid_wd;
        end
        if (ctl.rd)
        begin
            mid_rd_reg <= mid_mem[mid_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[top_wa] <= top_wd;
        end
        if (ctl.rd)
        begin
            top_rd_reg <= top_mem[top_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.leaf_stage)
        begin
            leaf_val_reg <= leaf_val_next;
        end
        if (ctl.mid_stage)
        begin
            mid_val_reg <= mid_val_next;
        end
        if (ctl.top_stage)
        begin
            top_val_reg <= top_val_next;
        end
        if (ctl.est_stage)
        begin
            estimate_reg <= estimate_next;
        end
    end

    assign estimate = estimate_reg;

endmodule

`default_nettype wire

### hw/rtl/tiered_counter_sketch_update.sv
// Top level of the tiered counter sketch update: sequencer, two counter trees,
// output register. Depends on tcsu_pkg, tcsu_tree and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "tiered_counter_sketch_update_defines.svh"

// Updates two three-level counter trees with one word (two leaf indices and an
// increment) and returns the smaller of the two tree estimates. After reset the
// block sweeps all counter memories to zero, one leaf entry per cycle, and
// req_stall stays high until it is done. Each word then goes from acceptance
// to the next acceptance through these steps: one memory read, then the leaf,
// middle and top levels each modify and write back in a state of their own,
// then the estimate, then the minimum into the output register, then back in
// idle where the next word is taken. The result sits in an output register,
// so a word is taken while the previous result waits; if that result is
// still waiting when the next minimum is ready, the block holds there until
// it leaves.
module tiered_counter_sketch_update
    import tcsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [IDX_W-1:0] leaf_index_a,
    input  logic [IDX_W-1:0] leaf_index_b,
    input  logic [INC_W-1:0] increment,
    output logic             res_valid,
    input  logic             res_stall,
    output logic [EST_W-1:0] estimate
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_LEAF  = 8'b0000_1000,
        ST_MID   = 8'b0001_0000,
        ST_TOP   = 8'b0010_0000,
        ST_EST   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [LEAF_AW-1:0] clear_addr_reg, clear_addr_next;
    logic [IDX_W-1:0]   idx_a_reg, idx_b_reg;
    logic [INC_W-1:0]   inc_reg;
    logic               res_valid_reg, res_valid_next;
    logic [EST_W-1:0]   estimate_reg;
    logic [EST_W-1:0]   est_a, est_b, est_min;
    logic               req_accept, res_load;
    tree_ctl_t          ctl;

    assign req_accept = req_valid && !req_stall;
    assign req_stall  = (state_reg != ST_IDLE);
    assign res_load   = (state_reg == ST_DONE) && (!res_valid_reg || !res_stall);
    assign est_min    = (est_a < est_b) ? est_a : est_b;

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_addr_next = clear_addr_reg + LEAF_AW'(1);
                if (&clear_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_LEAF;
            ST_LEAF: state_next = ST_MID;
            ST_MID:  state_next = ST_TOP;
            ST_TOP:  state_next = ST_EST;
            ST_EST:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        ctl.clear      = (state_reg == ST_CLEAR);
        ctl.clear_addr = clear_addr_reg;
        ctl.rd         = (state_reg == ST_READ);
        ctl.leaf_stage = (state_reg == ST_LEAF);
        ctl.mid_stage  = (state_reg == ST_MID);
        ctl.top_stage  = (state_reg == ST_TOP);
        ctl.est_stage  = (state_reg == ST_EST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            idx_a_reg <= leaf_index_a;
            idx_b_reg <= leaf_index_b;
            inc_reg   <= increment;
        end
        if (res_load)
        begin
            estimate_reg <= est_min;
        end
    end

    tcsu_tree u_tree_a (
        .clk        (clk),
        .leaf_index (idx_a_reg),
        .increment  (inc_reg),
        .ctl        (ctl),
        .estimate   (est_a)
    );

    tcsu_tree u_tree_b (
        .clk        (clk),
        .leaf_index (idx_b_reg),
        .increment  (inc_reg),
        .ctl        (ctl),
        .estimate   (est_b)
    );

    assign res_valid = res_valid_reg;
    assign estimate  = estimate_reg;

    `TCSU_ASSERT(a_accept_starts_read, req_accept |=> (state_reg == ST_READ), "accepted word did not start a read")
    `TCSU_ASSERT(a_result_from_done, $rose(res_valid_reg) |-> $past(state_reg == ST_DONE), "result without a finished update")
    `TCSU_ASSERT_ALWAYS(a_no_result_in_clear, (state_reg == ST_CLEAR) |-> !res_valid_reg, "result during clearing sweep")

endmodule

`default_nettype wire
